### rtl/edu_register_device_factorial_dma_assert.svh
// ----------------------------------------------------------------------------
// edu device assertion macros
// shared property forms for the checker of the register device
// ----------------------------------------------------------------------------
`ifndef EDU_REGISTER_DEVICE_FACTORIAL_DMA_ASSERT_SVH
`define EDU_REGISTER_DEVICE_FACTORIAL_DMA_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define EDUFDMA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edufdma assertion failed");

// next-cycle implication, off while reset is asserted
`define EDUFDMA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edufdma assertion failed");

`endif

### rtl/edufdma_pkg.sv
// ----------------------------------------------------------------------------
// edufdma_pkg
// types, register codes and constants of the edu register device
// ----------------------------------------------------------------------------
package edufdma_pkg;

	localparam int unsigned BUF_OFFSET_BITS_DEF = 28;

	// operation codes
	localparam logic [1:0] OP_READ     = 2'd0;
	localparam logic [1:0] OP_WRITE    = 2'd1;
	localparam logic [1:0] OP_DMA_DONE = 2'd2;

	// register select codes
	localparam logic [3:0] REG_ID        = 4'd0;
	localparam logic [3:0] REG_LIVENESS  = 4'd1;
	localparam logic [3:0] REG_FACT      = 4'd2;
	localparam logic [3:0] REG_FSTATUS   = 4'd3;
	localparam logic [3:0] REG_INTSTATUS = 4'd4;
	localparam logic [3:0] REG_INTACK    = 4'd5;
	localparam logic [3:0] REG_DSRC      = 4'd6;
	localparam logic [3:0] REG_DDST      = 4'd7;
	localparam logic [3:0] REG_DLEN      = 4'd8;
	localparam logic [3:0] REG_DCMD      = 4'd9;

	localparam logic [2:0] BAR_SERVED  = 3'd0;
	localparam logic [3:0] BYTES_NARROW = 4'd4;
	localparam logic [3:0] BYTES_WIDE   = 4'd8;

	localparam logic [31:0] ID_VALUE      = 32'h010000ED;
	localparam logic [31:0] FACT_IRQ_EN   = 32'h00000080;
	localparam logic [31:0] FACT_IRQ_BIT  = 32'h00000001;
	localparam logic [31:0] DMA_IRQ_BIT   = 32'h00000100;
	localparam logic [31:0] FACT_LIMIT    = 32'd34;
	localparam logic [31:0] FACT_TRIVIAL  = 32'd2;

	localparam int unsigned OFFSET_W = 28;
	localparam int unsigned LENGTH_W = 29;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  bar_number;
		logic [3:0]  register_select;
		logic [3:0]  access_bytes;
		logic [63:0] write_data;
	} req_t;

	typedef struct packed {
		logic [63:0]         read_data;
		logic                access_error;
		logic                interrupt_pulse;
		logic                dma_start;
		logic [63:0]         dma_host_address;
		logic [OFFSET_W-1:0] dma_buffer_offset;
		logic [LENGTH_W-1:0] dma_length;
		logic                dma_to_host;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_FACT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic fact_step;
		logic fact_finish;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fact_long;
		logic fact_last;
	} dp_sts_t;

endpackage

### rtl/edufdma_ctrl.sv
// ----------------------------------------------------------------------------
// edufdma_ctrl
// sequencer for item acceptance, factorial iteration and result hand-off
// ----------------------------------------------------------------------------
module edufdma_ctrl import edufdma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q, rsp_valid_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take && sts.fact_long) begin
					state_d = ST_FACT;
				end
			end
			ST_FACT: begin
				if (sts.fact_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall       = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
		cmd.take        = req_valid && !req_stall;
		cmd.fact_step   = (state_q == ST_FACT) && !sts.fact_last;
		cmd.fact_finish = (state_q == ST_FACT) && sts.fact_last;
		rsp_valid_d     = rsp_valid_q && rsp_stall;
		if ((cmd.take && !sts.fact_long) || cmd.fact_finish) begin
			rsp_valid_d = 1'b1;
		end
		rsp_valid = rsp_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

### rtl/edufdma_dp.sv
// ----------------------------------------------------------------------------
// edufdma_dp
// register file, access decode, factorial multiplier and dma request build
// ----------------------------------------------------------------------------
module edufdma_dp import edufdma_pkg::*; #(
	parameter int unsigned BUFFER_OFFSET_BITS = BUF_OFFSET_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_sts_t  sts,
	output rsp_t     rsp
);

	localparam logic [63:0] BUF_SIZE = 64'd1 << BUFFER_OFFSET_BITS;

	logic [31:0] live_q, fact_q, fstat_q, istat_q;
	logic [63:0] dsrc_q, ddst_q, dlen_q, dcmd_q;
	logic [31:0] acc_q;
	logic [5:0]  k_q;
	rsp_t        rsp_q, rsp_d;

	logic [31:0] w32;
	logic        size_ok, good, is_rd, wr_ok, is_done;
	logic        fact_go, fact_big, fact_small, dcmd_go, start, done_go;
	logic [31:0] fact_now, istat_d;
	logic [63:0] bufaddr, boff, blen;

	always_comb begin
		w32     = req.write_data[31:0];
		size_ok = (req.register_select <= REG_INTACK) ? (req.access_bytes == BYTES_NARROW)
		                                               : (req.access_bytes == BYTES_WIDE);
		good    = (req.bar_number == BAR_SERVED)
		       && (req.register_select inside {[REG_ID:REG_DCMD]}) && size_ok;
		is_rd   = req.operation == OP_READ;
		wr_ok   = (req.operation == OP_WRITE) && good
		       && (req.register_select != REG_ID) && (req.register_select != REG_INTSTATUS);
		is_done = req.operation == OP_DMA_DONE;

		fact_go    = wr_ok && (req.register_select == REG_FACT) && !fstat_q[0];
		fact_big   = w32 >= FACT_LIMIT;
		fact_small = w32 < FACT_TRIVIAL;
		fact_now   = fact_big ? 32'd0 : 32'd1;

		dcmd_go = wr_ok && (req.register_select == REG_DCMD) && !dcmd_q[0];
		start   = dcmd_go && req.write_data[0];
		done_go = is_done && dcmd_q[0];

		bufaddr = req.write_data[1] ? dsrc_q : ddst_q;
		boff    = bufaddr & (BUF_SIZE - 64'd1);
		blen    = (dlen_q > BUF_SIZE) ? BUF_SIZE : dlen_q;

		istat_d = istat_q;
		if (fact_go && ((fstat_q & FACT_IRQ_EN) != '0)) begin
			istat_d = istat_d | FACT_IRQ_BIT;
		end
		if (wr_ok && (req.register_select == REG_INTACK)) begin
			istat_d = istat_d & ~w32;
		end
		if (done_go && dcmd_q[2]) begin
			istat_d = istat_d | DMA_IRQ_BIT;
		end

		rsp_d = '0;
		if (is_rd) begin
			if (!good) begin
				rsp_d.access_error = 1'b1;
			end else begin
				case (req.register_select)
					REG_ID:        rsp_d.read_data = {32'd0, ID_VALUE};
					REG_LIVENESS:  rsp_d.read_data = {32'd0, live_q};
					REG_FACT:      rsp_d.read_data = {32'd0, fact_q};
					REG_FSTATUS:   rsp_d.read_data = {32'd0, fstat_q};
					REG_INTSTATUS: rsp_d.read_data = {32'd0, istat_q};
					REG_DSRC:      rsp_d.read_data = dsrc_q;
					REG_DDST:      rsp_d.read_data = ddst_q;
					REG_DLEN:      rsp_d.read_data = dlen_q;
					REG_DCMD:      rsp_d.read_data = dcmd_q;
					default:       rsp_d.read_data = '0;
				endcase
			end
		end else if (req.operation == OP_WRITE) begin
			rsp_d.access_error    = !wr_ok;
			rsp_d.interrupt_pulse = fact_go && ((fstat_q & FACT_IRQ_EN) != '0);
			if (start) begin
				rsp_d.dma_start         = 1'b1;
				rsp_d.dma_to_host       = req.write_data[1];
				rsp_d.dma_host_address  = req.write_data[1] ? ddst_q : dsrc_q;
				rsp_d.dma_buffer_offset = boff[OFFSET_W-1:0];
				rsp_d.dma_length        = blen[LENGTH_W-1:0];
			end
		end else if (done_go) begin
			rsp_d.interrupt_pulse = dcmd_q[2];
		end

		sts.fact_long = fact_go && !fact_big && !fact_small;
		sts.fact_last = k_q <= 6'd1;
		rsp           = rsp_q;
	end

	// architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			fact_q  <= '0;
			fstat_q <= '0;
			istat_q <= '0;
			dsrc_q  <= '0;
			ddst_q  <= '0;
			dlen_q  <= '0;
			dcmd_q  <= '0;
		end else if (cmd.take) begin
			istat_q <= istat_d;
			if (wr_ok) begin
				case (req.register_select)
					REG_LIVENESS: live_q  <= ~w32;
					REG_FSTATUS:  fstat_q <= {31'd0, fstat_q[0]} | w32;
					REG_DSRC:     dsrc_q  <= req.write_data;
					REG_DDST:     ddst_q  <= req.write_data;
					REG_DLEN:     dlen_q  <= req.write_data;
					default:      ;
				endcase
			end
			if (fact_go && (fact_big || fact_small)) begin
				fact_q <= fact_now;
			end
			if (dcmd_go) begin
				dcmd_q <= req.write_data;
			end
			if (done_go) begin
				dcmd_q[0] <= 1'b0;
			end
		end else if (cmd.fact_finish) begin
			fact_q <= acc_q;
		end
	end

	// factorial accumulator, down counter and result register, one multiply per cycle
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			acc_q <= w32;
			k_q   <= w32[5:0] - 6'd1;
			rsp_q <= rsp_d;
		end else if (cmd.fact_step) begin
			acc_q <= 32'(acc_q * {26'd0, k_q});
			k_q   <= k_q - 6'd1;
		end
	end

endmodule

### rtl/edu_register_device_factorial_dma.sv
// ----------------------------------------------------------------------------
// edu_register_device_factorial_dma
// register-mapped teaching device: id, liveness, factorial unit, dma engine
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_t: bus read, write, dma done
//   rsp     | out       | rsp_valid/rsp_stall | rsp_t: read data, error, irq, dma
//
// most items produce a registered result in the cycle after acceptance
// a factorial write of n (2..33) iterates through one 32x6 multiplier
// the device holds req_stall while it iterates or while a result is stalled
// arst_n clears the device registers to zero and empties the result register
// ----------------------------------------------------------------------------
module edu_register_device_factorial_dma import edufdma_pkg::*; #(
	parameter int unsigned BUFFER_OFFSET_BITS = BUF_OFFSET_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// controller: acceptance, iteration and result valid
	edufdma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: registers, decode, multiplier, result register
	edufdma_dp #(
		.BUFFER_OFFSET_BITS (BUFFER_OFFSET_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

### rtl/edufdma_chk.sv
// ----------------------------------------------------------------------------
// edufdma_chk
// port-level checker for the edu register device, bound to the top level
// ----------------------------------------------------------------------------
`include "edu_register_device_factorial_dma_assert.svh"

module edufdma_chk import edufdma_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// stalled result holds
	`EDUFDMA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// no item taken while the result register is blocked
	`EDUFDMA_ASSERT_NOW(a_no_take_blocked, rsp_valid && rsp_stall, req_stall)

	// a failed access has no side effects on the result
	`EDUFDMA_ASSERT_NOW(a_err_quiet, rsp_valid && rsp.access_error,
		rsp.read_data == '0 && !rsp.dma_start && !rsp.interrupt_pulse)

	// dma fields are zero unless a copy is requested
	`EDUFDMA_ASSERT_NOW(a_dma_idle_zero, rsp_valid && !rsp.dma_start,
		rsp.dma_host_address == '0 && rsp.dma_length == '0 && !rsp.dma_to_host)

endmodule

bind edu_register_device_factorial_dma edufdma_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
